// ----- rtl/core/wgap_pkg.sv -----
// Shared types, constants and control store for the waveguide allpass core.
`default_nettype none

package wgap_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int COEF_W      = 18;
  localparam int COEF_SHIFT  = 17;
  localparam int DLEN_W      = 15;
  localparam int DEPTH_DEF   = 32768;
  localparam int PROD_W      = SAMPLE_W + COEF_W + 2;
  localparam int RQ_W        = PROD_W - COEF_SHIFT;
  localparam int ACC_W       = SAMPLE_W + 4;
  localparam int PC_W        = 3;
  localparam int CFG_IDX_W   = 3;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(131072);

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLPASS_COEF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_DECAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_FB      = 3'd4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } wgap_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } wgap_out_t;

  typedef struct packed {
    logic [DLEN_W-1:0] delay_length;
    logic [COEF_W-1:0] allpass_coef;
    logic [COEF_W-1:0] damping_radius;
    logic [COEF_W-1:0] feedback_decay;
    logic              invert_feedback;
  } wgap_cfg_t;

  typedef enum logic [2:0] {
    UOP_READ,
    UOP_MUL_AP,
    UOP_ADD_AP,
    UOP_MUL_DM,
    UOP_ADD_DM,
    UOP_MUL_OUT,
    UOP_ADD_OUT,
    UOP_WRITE
  } uop_t;

  typedef struct packed {
    uop_t            op;
    logic            jmp_ch;
    logic [PC_W-1:0] tgt;
    logic            last;
  } uword_t;

  typedef struct packed {
    uop_t op;
    logic ch;
    logic fire;
    logic load;
  } wgap_ctrl_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  function automatic uword_t wgap_urom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: UOP_READ, jmp_ch: 1'b0, tgt: '0, last: 1'b0};
    case (pc)
      3'd0: w.op = UOP_READ;
      3'd1: w.op = UOP_MUL_AP;
      3'd2: w.op = UOP_ADD_AP;
      3'd3: w.op = UOP_MUL_DM;
      3'd4: w.op = UOP_ADD_DM;
      3'd5: w.op = UOP_MUL_OUT;
      3'd6: begin
        w.op     = UOP_ADD_OUT;
        w.jmp_ch = 1'b1;
        w.tgt    = 3'd1;
      end
      3'd7: begin
        w.op   = UOP_WRITE;
        w.last = 1'b1;
      end
      default: w.op = UOP_READ;
    endcase
    return w;
  endfunction

  function automatic logic [COEF_W-1:0] wgap_clamp(input logic [COEF_W-1:0] c);
    return (c > COEF_ONE) ? COEF_ONE : c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] wgap_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (v > hi) begin
      return hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_W-1:0];
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/wgap_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module wgap_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/wgap_useq.sv -----
// Microcode sequencer: step counter, channel loop and control store lookup.
`default_nettype none

module wgap_useq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic                out_busy,
  output      wgap_pkg::wgap_ctrl_t ctrl
);

  wgap_pkg::seq_state_t          state_r, state_nxt;
  logic [wgap_pkg::PC_W-1:0]     pc_r, pc_nxt;
  logic                          ch_r, ch_nxt;
  wgap_pkg::uword_t              uword;
  logic                          hold;

  assign uword = wgap_pkg::wgap_urom(pc_r);
  assign hold  = (uword.op == wgap_pkg::UOP_WRITE) && out_busy;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    ch_nxt    = ch_r;
    case (state_r)
      wgap_pkg::SEQ_IDLE: begin
        if (in_valid) begin
          state_nxt = wgap_pkg::SEQ_RUN;
          pc_nxt    = '0;
          ch_nxt    = 1'b0;
        end
      end
      wgap_pkg::SEQ_RUN: begin
        if (!hold) begin
          if (uword.last) begin
            state_nxt = wgap_pkg::SEQ_IDLE;
          end else if (uword.jmp_ch && !ch_r) begin
            pc_nxt = uword.tgt;
            ch_nxt = 1'b1;
          end else begin
            pc_nxt = pc_r + wgap_pkg::PC_W'(1);
          end
        end
      end
      default: state_nxt = wgap_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != wgap_pkg::SEQ_IDLE);
    ctrl.op   = uword.op;
    ctrl.ch   = ch_r;
    ctrl.fire = (state_r == wgap_pkg::SEQ_RUN) && !hold;
    ctrl.load = (state_r == wgap_pkg::SEQ_IDLE) && in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wgap_pkg::SEQ_IDLE;
      pc_r    <= '0;
      ch_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      ch_r    <= ch_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/wgap_dpath.sv -----
// Datapath: shared multiplier, rounding adder, saturation, filter state, output register.
`default_nettype none

module wgap_dpath #(
  parameter int DELAY_DEPTH = wgap_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire wgap_pkg::wgap_cfg_t                 cfg,
  input  wire wgap_pkg::wgap_ctrl_t                ctrl,
  input  wire wgap_pkg::wgap_in_t                  in_data,
  input  wire logic                                out_stall,
  output      logic                                out_valid,
  output      wgap_pkg::wgap_out_t                 out_data,
  output      logic                                out_busy,
  output      logic                                ram_re,
  output      logic [$clog2(DELAY_DEPTH)-1:0]      ram_raddr,
  output      logic                                ram_we,
  output      logic [$clog2(DELAY_DEPTH)-1:0]      ram_waddr,
  output      logic [2*wgap_pkg::SAMPLE_W-1:0]     ram_wdata,
  input  wire logic [2*wgap_pkg::SAMPLE_W-1:0]     ram_rdata
);

  localparam int AW   = $clog2(DELAY_DEPTH);
  localparam int SW   = wgap_pkg::SAMPLE_W;
  localparam int CW   = wgap_pkg::COEF_W;
  localparam int PW   = wgap_pkg::PROD_W;
  localparam int RQW  = wgap_pkg::RQ_W;
  localparam int ACCW = wgap_pkg::ACC_W;
  localparam int SH   = wgap_pkg::COEF_SHIFT;
  localparam logic signed [PW-1:0] RND_HALF =
    {{(PW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};

  wgap_pkg::wgap_in_t  in_r, in_nxt;
  wgap_pkg::wgap_out_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [AW-1:0]       wp_r, wp_nxt;
  logic                wrapped_r, wrapped_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic signed [SW-1:0] apo_r [2];
  logic signed [SW-1:0] apo_nxt [2];
  logic signed [SW-1:0] aip_r [2];
  logic signed [SW-1:0] aip_nxt [2];
  logic signed [SW-1:0] dmp_r [2];
  logic signed [SW-1:0] dmp_nxt [2];
  logic signed [SW-1:0] o_r [2];
  logic signed [SW-1:0] o_nxt [2];
  logic signed [SW-1:0] w_r [2];
  logic signed [SW-1:0] w_nxt [2];
  logic signed [PW-1:0] prod_r, prod_nxt;

  logic [AW-1:0]         rp;
  logic signed [SW-1:0]  x;
  logic signed [SW-1:0]  apo_c;
  logic signed [SW-1:0]  dmp_c;
  logic signed [SW-1:0]  in_c;
  logic signed [SW:0]    mul_a;
  logic [CW-1:0]         coef;
  logic signed [CW:0]    mul_c;
  logic signed [PW-1:0]  mul_p;
  logic signed [PW-1:0]  rsum;
  logic signed [RQW-1:0] rq;
  logic signed [SW-1:0]  add_base;
  logic signed [ACCW-1:0] acc;
  logic signed [SW-1:0]  sat_v;
  logic signed [ACCW-1:0] fb_sum;
  logic signed [SW-1:0]  w_v;

  assign rp    = wp_r - AW'(cfg.delay_length);
  assign x     = !rd_ok_r ? '0 :
                 ctrl.ch ? $signed(ram_rdata[2*SW-1:SW]) : $signed(ram_rdata[SW-1:0]);
  assign apo_c = apo_r[ctrl.ch];
  assign dmp_c = dmp_r[ctrl.ch];
  assign in_c  = ctrl.ch ? in_r.right_in : in_r.left_in;

  always_comb begin
    case (ctrl.op)
      wgap_pkg::UOP_MUL_AP: begin
        mul_a = (SW+1)'(x) - (SW+1)'(apo_c);
        coef  = cfg.allpass_coef;
      end
      wgap_pkg::UOP_MUL_DM: begin
        mul_a = (SW+1)'(apo_c) - (SW+1)'(dmp_c);
        coef  = cfg.damping_radius;
      end
      wgap_pkg::UOP_MUL_OUT: begin
        mul_a = (SW+1)'(dmp_c);
        coef  = cfg.feedback_decay;
      end
      default: begin
        mul_a = '0;
        coef  = '0;
      end
    endcase
  end

  assign mul_c = $signed({1'b0, wgap_pkg::wgap_clamp(coef)});
  assign mul_p = mul_a * mul_c;

  assign rsum = prod_r + RND_HALF;
  assign rq   = $signed(rsum[PW-1:SH]);

  always_comb begin
    case (ctrl.op)
      wgap_pkg::UOP_ADD_AP: add_base = aip_r[ctrl.ch];
      wgap_pkg::UOP_ADD_DM: add_base = dmp_c;
      default:              add_base = '0;
    endcase
  end

  assign acc    = ACCW'(add_base) + ACCW'(rq);
  assign sat_v  = wgap_pkg::wgap_sat(acc);
  assign fb_sum = cfg.invert_feedback ? (ACCW'(in_c) - ACCW'(sat_v))
                                      : (ACCW'(in_c) + ACCW'(sat_v));
  assign w_v    = wgap_pkg::wgap_sat(fb_sum);

  always_comb begin
    in_nxt        = in_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    wp_nxt        = wp_r;
    wrapped_nxt   = wrapped_r;
    rd_ok_nxt     = rd_ok_r;
    prod_nxt      = prod_r;
    for (int i = 0; i < 2; i++) begin
      apo_nxt[i] = apo_r[i];
      aip_nxt[i] = aip_r[i];
      dmp_nxt[i] = dmp_r[i];
      o_nxt[i]   = o_r[i];
      w_nxt[i]   = w_r[i];
    end
    ram_re = 1'b0;
    ram_we = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.load) begin
      in_nxt = in_data;
    end
    if (ctrl.fire) begin
      case (ctrl.op)
        wgap_pkg::UOP_READ: begin
          ram_re    = 1'b1;
          rd_ok_nxt = wrapped_r || (rp < wp_r);
        end
        wgap_pkg::UOP_MUL_AP,
        wgap_pkg::UOP_MUL_DM,
        wgap_pkg::UOP_MUL_OUT: begin
          prod_nxt = mul_p;
        end
        wgap_pkg::UOP_ADD_AP: begin
          apo_nxt[ctrl.ch] = sat_v;
          aip_nxt[ctrl.ch] = x;
        end
        wgap_pkg::UOP_ADD_DM: begin
          dmp_nxt[ctrl.ch] = sat_v;
        end
        wgap_pkg::UOP_ADD_OUT: begin
          o_nxt[ctrl.ch] = sat_v;
          w_nxt[ctrl.ch] = w_v;
        end
        wgap_pkg::UOP_WRITE: begin
          ram_we            = 1'b1;
          wp_nxt            = wp_r + AW'(1);
          if (wp_r == {AW{1'b1}}) begin
            wrapped_nxt = 1'b1;
          end
          out_nxt.left_out  = o_r[0];
          out_nxt.right_out = o_r[1];
          out_valid_nxt     = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign ram_raddr = rp;
  assign ram_waddr = wp_r;
  assign ram_wdata = {w_r[1], w_r[0]};
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_busy  = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      rd_ok_r     <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        apo_r[i] <= '0;
        aip_r[i] <= '0;
        dmp_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
      rd_ok_r     <= rd_ok_nxt;
      for (int i = 0; i < 2; i++) begin
        apo_r[i] <= apo_nxt[i];
        aip_r[i] <= aip_nxt[i];
        dmp_r[i] <= dmp_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    out_r  <= out_nxt;
    prod_r <= prod_nxt;
    for (int i = 0; i < 2; i++) begin
      o_r[i] <= o_nxt[i];
      w_r[i] <= w_nxt[i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/waveguide_allpass_damped_feedback_core.sv -----
// Top level: stereo damped waveguide section with allpass fractional delay.
// Sequencing: the microcode program runs both channels through one shared
// multiplier; the result is registered after the write step, which waits while an
// earlier result is still stalled, and a new frame is taken only back in idle.
// Reset: synchronous; clears filter state, write position and fill flag, loads
// register defaults. Unwritten delay entries read as zero via the fill flag.
`default_nettype none

module waveguide_allpass_damped_feedback_core #(
  parameter int DELAY_DEPTH = wgap_pkg::DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire wgap_pkg::wgap_in_t                 in_data,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      wgap_pkg::wgap_out_t                out_data,
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [wgap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wgap_pkg::COEF_W-1:0]        cfg_data
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int SW = wgap_pkg::SAMPLE_W;

  wgap_pkg::wgap_cfg_t  cfg_r, cfg_nxt;
  wgap_pkg::wgap_ctrl_t ctrl;
  logic                 out_busy;
  logic                 ram_re;
  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [AW-1:0]        ram_waddr;
  logic [2*SW-1:0]      ram_wdata;
  logic [2*SW-1:0]      ram_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wgap_pkg::CFG_DELAY_LENGTH:   cfg_nxt.delay_length = cfg_data[wgap_pkg::DLEN_W-1:0];
        wgap_pkg::CFG_ALLPASS_COEF:   cfg_nxt.allpass_coef = cfg_data;
        wgap_pkg::CFG_DAMPING_RADIUS: cfg_nxt.damping_radius = cfg_data;
        wgap_pkg::CFG_FEEDBACK_DECAY: cfg_nxt.feedback_decay = cfg_data;
        wgap_pkg::CFG_INVERT_FB:      cfg_nxt.invert_feedback = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_length    <= wgap_pkg::DLEN_W'(100);
      cfg_r.allpass_coef    <= wgap_pkg::COEF_ONE;
      cfg_r.damping_radius  <= '0;
      cfg_r.feedback_decay  <= '0;
      cfg_r.invert_feedback <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wgap_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_busy (out_busy),
    .ctrl     (ctrl)
  );

  wgap_dpath #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ctrl      (ctrl),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_busy  (out_busy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  wgap_ram #(
    .WIDTH (2*SW),
    .DEPTH (DELAY_DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer did not start after transfer");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctrl.fire && (ctrl.op == wgap_pkg::UOP_WRITE)))
    else $error("result raised without write step");

  a_write_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.fire && (ctrl.op == wgap_pkg::UOP_WRITE)) |=> !in_stall)
    else $error("sequencer still busy after write step");

endmodule

`default_nettype wire
